FILE: src/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types, constants and codes shared by the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Fixed field widths of the item interface
  localparam int FLD_IDX_W  = 4;
  localparam int FLD_SIZE_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Input command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Result status codes
  localparam logic STATUS_ALLOCATED = 1'b0;
  localparam logic STATUS_REFUSED   = 1'b1;

  // Fit policy codes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_BEST  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic                  cmd;
    logic [FLD_IDX_W-1:0]  load_index;
    logic [FLD_SIZE_W-1:0] load_size;
    logic [FLD_SIZE_W-1:0] request_size;
    logic                  request_last;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [FLD_IDX_W-1:0]  granted_index;
    logic [FLD_SIZE_W-1:0] remaining_size;
    logic                  batch_end;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // write one table entry from the input beat
    logic start;   // latch a request and clear the search
    logic scan;    // examine one table entry
    logic commit;  // write back and load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer for the allocator: accept, scan the table, commit the result.
// ----------------------------------------------------------------------------
module fpba_ctrl import fpba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cmd_i == CMD_REQUEST)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register can take the beat
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i && (in_cmd_i == CMD_LOAD);
        cmd_o.start  = in_valid_i && (in_cmd_i == CMD_REQUEST);
      end
      ST_SCAN: begin
        cmd_o.scan   = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        in_ready_o   = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/fpba_dp.sv
// ----------------------------------------------------------------------------
// fpba_dp
// Free-size table, configuration registers, search unit and result register.
// ----------------------------------------------------------------------------
module fpba_dp import fpba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  in_item_t              in_data_i,
  input  logic                  cfg_write_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  logic [SIZE_BITS-1:0]  table_q [NUM_BLOCKS];

  logic                  fit_mode_q;
  logic [CFG_DATA_W-1:0] block_count_q;

  logic [SIZE_BITS-1:0]  want_q;
  logic                  last_q;
  logic [CNT_W-1:0]      idx_q;
  logic                  found_q;
  logic [IDX_W-1:0]      chosen_q;
  logic [SIZE_BITS-1:0]  best_q;

  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic [CNT_W-1:0]      active;
  logic [CNT_W-1:0]      idx_inc;
  logic [SIZE_BITS-1:0]  entry;
  logic                  in_range;
  logic                  fits;
  logic                  take;
  logic                  load_ok;
  logic [SIZE_BITS-1:0]  remaining;

  // Entries searched: block_count clamped to the table depth
  always_comb begin
    if (int'(block_count_q) > NUM_BLOCKS) begin
      active = CNT_W'(NUM_BLOCKS);
    end else begin
      active = CNT_W'(block_count_q);
    end
  end

  assign idx_inc  = idx_q + 1'b1;
  assign in_range = (idx_q < active);
  assign entry    = table_q[idx_q[IDX_W-1:0]];
  assign fits     = in_range && (entry >= want_q);
  // first fit takes any fit; best fit takes the first fit, then only a strictly smaller one
  assign take     = fits && ((fit_mode_q == FIT_FIRST) || !found_q || (entry < best_q));

  assign status_o.scan_done = !in_range || (idx_inc >= active) ||
                              ((fit_mode_q == FIT_FIRST) && fits);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign load_ok   = (int'(in_data_i.load_index) < NUM_BLOCKS);
  assign remaining = best_q - want_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_FIRST;
      block_count_q <= BLOCK_COUNT_RESET;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Free-size table: one write per cycle, from a load beat or a commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        table_q[i] <= '0;
      end
    end else if (cmd_i.load && load_ok) begin
      table_q[IDX_W'(in_data_i.load_index)] <= SIZE_BITS'(in_data_i.load_size);
    end else if (cmd_i.commit && found_q) begin
      table_q[chosen_q] <= remaining;
    end
  end

  // Search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q   <= idx_inc;
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      want_q <= SIZE_BITS'(in_data_i.request_size);
      last_q <= in_data_i.request_last;
    end
    if (cmd_i.scan && take) begin
      chosen_q <= idx_q[IDX_W-1:0];
      best_q   <= entry;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q.batch_end <= last_q;
      if (found_q) begin
        out_data_q.status         <= STATUS_ALLOCATED;
        out_data_q.granted_index  <= FLD_IDX_W'(chosen_q);
        out_data_q.remaining_size <= FLD_SIZE_W'(remaining);
      end else begin
        out_data_q.status         <= STATUS_REFUSED;
        out_data_q.granted_index  <= '0;
        out_data_q.remaining_size <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// First-fit / best-fit allocator over a table of block free sizes.
// ----------------------------------------------------------------------------
// A load beat writes one table entry and is taken with no result. A request
// beat is accepted, then the scan examines one table entry per cycle (up to
// min(block_count, 16) entries, fewer in first-fit mode when an early entry
// fits), then a commit writes the reduced size back to a granted entry and
// loads the result register. No new item is accepted until the commit is done.
// The result register holds a finished beat while the next item is accepted
// and scanned; the commit waits only if the previous result has not yet been
// taken. The table is cleared by reset. Configuration writes are taken in
// any cycle and are meant for when the block is idle.
module fit_policy_block_allocator import fpba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  fpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  fpba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/fpba_grant_checker.sv
// ----------------------------------------------------------------------------
// fpba_grant_checker
// Watches the item, result and register channels of the block allocator. It
// keeps its own copy of the free-size table and the fit settings, works out
// the grant for every request beat and compares each result beat with the
// oldest grant still owed.
// ----------------------------------------------------------------------------
module fpba_grant_checker import fpba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  logic [FLD_SIZE_W-1:0] free_size [NUM_BLOCKS];
  logic                  fit_mode;
  logic [CFG_DATA_W-1:0] blk_count;
  out_item_t             grant_q [$];
  int                    mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch({what, " mismatch"}, got, want);
  endtask

  // Loads update the table; requests search it and queue the grant they owe.
  task automatic apply_beat(input in_item_t b);
    out_item_t r;
    int        span;
    int        pick;
    if (b.cmd == CMD_LOAD) begin
      free_size[b.load_index] = b.load_size;
    end else begin
      span = (int'(blk_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(blk_count);
      pick = -1;
      for (int j = 0; j < span; j++) begin
        if (free_size[j] >= b.request_size) begin
          if (fit_mode == FIT_FIRST) begin
            if (pick < 0) pick = j;
          end else if (pick < 0 || free_size[j] < free_size[pick]) begin
            pick = j;
          end
        end
      end
      r.batch_end = b.request_last;
      if (pick < 0) begin
        r.status         = STATUS_REFUSED;
        r.granted_index  = '0;
        r.remaining_size = '0;
      end else begin
        free_size[pick]  = free_size[pick] - b.request_size;
        r.status         = STATUS_ALLOCATED;
        r.granted_index  = FLD_IDX_W'(pick);
        r.remaining_size = free_size[pick];
      end
      grant_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int j = 0; j < NUM_BLOCKS; j++) free_size[j] = '0;
      fit_mode  = FIT_FIRST;
      blk_count = BLOCK_COUNT_RESET;
      grant_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FIT_MODE) fit_mode = cfg_data_i[0];
        else if (cfg_index_i == CFG_BLOCK_COUNT) blk_count = cfg_data_i;
      end
      // A result can never belong to a beat taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected result beat",
                          32'({out_data_i.status, out_data_i.granted_index,
                               out_data_i.remaining_size}), '0);
        end else begin
          want = grant_q.pop_front();
          check_field("status", 32'(out_data_i.status), 32'(want.status));
          check_field("granted_index", 32'(out_data_i.granted_index),
                      32'(want.granted_index));
          check_field("remaining_size", 32'(out_data_i.remaining_size),
                      32'(want.remaining_size));
          check_field("batch_end", 32'(out_data_i.batch_end),
                      32'(want.batch_end));
        end
      end
      if (in_valid_i && in_ready_i) apply_beat(in_data_i);
      pending_o <= grant_q.size();
    end
  end

endmodule

FILE: tb/fit_policy_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Drives load and request beats into the allocator under first-fit and
// best-fit settings and a range of search lengths, with random gaps on both
// channels and two long result back-pressure spells. Checking is left to
// fpba_grant_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int SEGMENTS         = 30;
  localparam int SEG_BEATS        = 42;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          pending;
  int          fail_count;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  logic        sink_hold     = 1'b0;
  int unsigned cycle_cnt     = 0;

  fit_policy_block_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  fpba_grant_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Fields that the command does not use carry junk.
  function automatic in_item_t load_beat(input int idx, input int size);
    in_item_t b;
    b.cmd          = CMD_LOAD;
    b.load_index   = FLD_IDX_W'(idx);
    b.load_size    = FLD_SIZE_W'(size);
    b.request_size = FLD_SIZE_W'($urandom);
    b.request_last = 1'($urandom);
    return b;
  endfunction

  function automatic in_item_t req_beat(input int size, input logic last);
    in_item_t b;
    b.cmd          = CMD_REQUEST;
    b.load_index   = FLD_IDX_W'($urandom);
    b.load_size    = FLD_SIZE_W'($urandom);
    b.request_size = FLD_SIZE_W'(size);
    b.request_last = last;
    return b;
  endfunction

  // Mostly small sizes so that requests keep hitting loaded entries and
  // best-fit ties turn up; full-range values and the extremes now and then.
  function automatic in_item_t random_beat();
    int pick;
    int size;
    pick = $urandom_range(9);
    if ($urandom_range(99) < 35) begin
      if (pick == 0) size = 0;
      else if (pick == 1) size = 16'hFFFF;
      else if (pick <= 4) size = $urandom_range(16'hFFFF);
      else size = $urandom_range(300);
      return load_beat($urandom_range(15), size);
    end
    if (pick == 0) size = 0;
    else if (pick == 1) size = 16'hFFFF;
    else if (pick == 2) size = $urandom_range(16'hFFFF);
    else size = $urandom_range(120);
    return req_beat(size, ($urandom_range(3) == 0));
  endfunction

  task automatic send_beat(input in_item_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Loads give no result, so the wait goes on past the last grant to let them settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] corner_count(input int k);
    case (k)
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return 5'd17;
      default: return 5'd2;
    endcase
  endfunction

  task automatic run_segment(input int seg, input logic hold);
    logic                  mode;
    logic [CFG_DATA_W-1:0] count;
    mode = 1'((seg / 10 + seg) & 1);
    if (seg % 10 < 6) count = corner_count(seg % 10);
    else if ($urandom_range(4) == 0) count = CFG_DATA_W'($urandom_range(31));
    else count = CFG_DATA_W'($urandom_range(1, 16));
    wait_idle();
    write_reg(CFG_FIT_MODE, {(CFG_DATA_W-1)'($urandom), mode});
    write_reg(CFG_BLOCK_COUNT, count);
    if (hold) sink_hold = 1'b1;
    for (int k = 0; k < SEG_BEATS; k++) send_beat(random_beat());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first fit over all sixteen entries, table empty.
    src_idle_pct  = 12;
    sink_idle_pct = 62;
    send_beat(req_beat(0, 1'b0));        // zero size fits an empty entry
    send_beat(req_beat(1, 1'b1));        // nothing fits
    send_beat(load_beat(0, 16'hFFFF));
    send_beat(load_beat(15, 1));
    send_beat(load_beat(5, 100));
    send_beat(load_beat(3, 100));
    send_beat(req_beat(16'hFFFF, 1'b1));
    send_beat(req_beat(50, 1'b0));
    send_beat(req_beat(100, 1'b0));
    send_beat(req_beat(1, 1'b1));

    wait_idle();
    write_reg(CFG_FIT_MODE, {4'b1111, FIT_BEST});
    send_beat(req_beat(1, 1'b0));        // smallest fit is the last entry
    send_beat(load_beat(7, 49));
    send_beat(req_beat(49, 1'b1));       // tie goes to the lower index
    send_beat(req_beat(0, 1'b0));

    wait_idle();
    write_reg(CFG_BLOCK_COUNT, 5'd0);    // nothing searched
    send_beat(req_beat(0, 1'b1));

    wait_idle();
    write_reg(CFG_BLOCK_COUNT, 5'd31);   // clamps to the whole table
    send_beat(load_beat(15, 16'hFFFF));
    send_beat(req_beat(16'hFFFE, 1'b0));

    wait_idle();
    write_reg(CFG_FIT_MODE, {4'b0000, FIT_FIRST});
    write_reg(CFG_BLOCK_COUNT, 5'd1);
    send_beat(req_beat(0, 1'b0));
    send_beat(load_beat(0, 16'h8000));
    send_beat(req_beat(16'h8000, 1'b1));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 10) begin
        src_idle_pct  = 62;
        sink_idle_pct = 12;
      end else if (seg == 20) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      run_segment(seg, (seg == 2 || seg == 25));
    end

    wait_idle();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/fpba_pkg.sv
src/fpba_ctrl.sv
src/fpba_dp.sv
src/fit_policy_block_allocator.sv
tb/fpba_grant_checker.sv
tb/fit_policy_block_allocator_tb.sv
